### src/rrs_pkg.sv
// ----------------------------------------------------------------------------
// Region reference-count sweeper package
// Shared constants, request and result types and table port structures.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int TableDepth = 32;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int IdxCntW    = $clog2(TableDepth + 1);
  localparam int CountW     = 16;
  localparam int AddrW      = 48;
  localparam int ThrW       = 16;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [1:0] ReqAdd  = 2'd0;
  localparam logic [1:0] ReqInc  = 2'd1;
  localparam logic [1:0] ReqDec  = 2'd2;
  localparam logic [1:0] ReqSync = 2'd3;

  localparam logic [2:0] StatDone     = 3'd0;
  localparam logic [2:0] StatFreed    = 3'd1;
  localparam logic [2:0] StatFull     = 3'd2;
  localparam logic [2:0] StatNoMatch  = 3'd3;
  localparam logic [2:0] StatDeferred = 3'd4;

  localparam logic RegThreshold = 1'b0;
  localparam logic RegEnable    = 1'b1;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [AddrW-1:0] region_start;
    logic [AddrW-1:0] region_length;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [AddrW-1:0] freed_start;
    logic [AddrW-1:0] freed_length;
    logic             last;
  } res_t;

  typedef struct packed {
    logic              entry_en;
    logic              count_en;
    logic [IdxW-1:0]   idx;
    logic [AddrW-1:0]  start;
    logic [AddrW-1:0]  length;
    logic [CountW-1:0] count;
  } tbl_wr_t;

  typedef struct packed {
    logic [AddrW-1:0]  start;
    logic [AddrW-1:0]  length;
    logic [CountW-1:0] count;
  } tbl_rd_t;

endpackage

### src/rrs_entry_mem.sv
// ----------------------------------------------------------------------------
// Region table storage
// Start, length and count memories with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module rrs_entry_mem (
  input  logic                      clk_i,
  input  logic [rrs_pkg::IdxW-1:0]  rd_idx_i,
  input  rrs_pkg::tbl_wr_t          wr_i,
  output rrs_pkg::tbl_rd_t          rd_o
);
  import rrs_pkg::*;

  logic [AddrW-1:0]  start_mem  [TableDepth];
  logic [AddrW-1:0]  length_mem [TableDepth];
  logic [CountW-1:0] count_mem  [TableDepth];

  always_ff @(posedge clk_i) begin
    if (wr_i.entry_en) begin
      start_mem[wr_i.idx]  <= wr_i.start;
      length_mem[wr_i.idx] <= wr_i.length;
    end
    if (wr_i.entry_en || wr_i.count_en) begin
      count_mem[wr_i.idx] <= wr_i.count;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_o.start  <= start_mem[rd_idx_i];
    rd_o.length <= length_mem[rd_idx_i];
    rd_o.count  <= count_mem[rd_idx_i];
  end

endmodule

### src/region_refcount_sweeper.sv
// ----------------------------------------------------------------------------
// Region reference-count sweeper
// Table of memory regions with reference counts, swept on sync requests.
//
// Channel    | Handshake                 | Payload
// -----------+---------------------------+-------------------
// request    | start && !busy            | req_i (req_t)
// result     | res_valid_o, one cycle    | res_o (res_t)
// config     | APB write, pready high    | paddr, pwdata
//
// A deferred sync does not raise busy. Every other request scans the table
// through one memory read port, one entry a cycle, and holds busy through the
// scan and finish states, so no new request is accepted until busy falls.
// Freed results appear during the scan and the final result in the cycle in
// which busy falls. Reset clears the used and dead bits, the deferral counter
// and the registers at once, so no clearing pass is needed. Results cannot be
// held off by the receiver.
// ----------------------------------------------------------------------------
module region_refcount_sweeper (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  rrs_pkg::req_t  req_i,
  output logic           res_valid_o,
  output rrs_pkg::res_t  res_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import rrs_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  state_e             state_q;
  req_t               req_q;
  logic [ThrW-1:0]    thr_q;
  logic               defer_en_q;
  logic [ThrW-1:0]    deferred_q;
  logic [TableDepth-1:0] used_q;
  logic [TableDepth-1:0] dead_q;
  logic [IdxCntW-1:0] rd_idx_q;
  logic [IdxW-1:0]    cmp_idx_q;
  logic               cmp_valid_q;
  logic               found_q;
  logic [IdxW-1:0]    found_idx_q;
  logic [CountW-1:0]  found_cnt_q;
  logic               free_q;
  logic [IdxW-1:0]    free_idx_q;
  logic               res_valid_q;
  res_t               res_q;

  tbl_wr_t            wr;
  tbl_rd_t            rd;
  logic               cfg_wr;
  logic               accept;
  logic               defer_now;
  logic               start_eq;
  logic               hit_add;
  logic               hit_live;
  logic               hit;
  logic               freed_ent;
  logic [CountW-1:0]  new_cnt;
  logic [IdxW-1:0]    wr_idx;
  logic [2:0]         fin_status;

  assign pready      = 1'b1;
  assign busy        = (state_q != StIdle);
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign accept      = start && !busy;
  assign defer_now   = (req_i.req_type == ReqSync) && defer_en_q && (deferred_q < thr_q);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    unique case (paddr[2])
      RegThreshold: prdata = {{(32 - ThrW){1'b0}}, thr_q};
      RegEnable:    prdata = {31'd0, defer_en_q};
      default:      prdata = 32'd0;
    endcase
  end

  assign start_eq  = (rd.start == req_q.region_start);
  assign hit_add   = cmp_valid_q && used_q[cmp_idx_q] && start_eq;
  assign hit_live  = hit_add && !dead_q[cmp_idx_q];
  assign hit       = (req_q.req_type == ReqAdd) ? hit_add : hit_live;
  assign freed_ent = cmp_valid_q && used_q[cmp_idx_q] && !dead_q[cmp_idx_q] &&
                     (rd.count == '0);

  always_comb begin
    new_cnt = found_cnt_q;
    if (found_cnt_q != '0) begin
      if (req_q.req_type == ReqInc) begin
        if (found_cnt_q != CountMax) begin
          new_cnt = found_cnt_q + CountW'(1);
        end
      end else begin
        new_cnt = found_cnt_q - CountW'(1);
      end
    end
  end

  always_comb begin
    if (req_q.req_type == ReqAdd && !found_q && !free_q) begin
      fin_status = StatFull;
    end else if ((req_q.req_type == ReqInc || req_q.req_type == ReqDec) &&
                 !found_q) begin
      fin_status = StatNoMatch;
    end else begin
      fin_status = StatDone;
    end
  end

  assign wr_idx = found_q ? found_idx_q : free_idx_q;

  always_comb begin
    wr          = '0;
    wr.idx      = wr_idx;
    wr.start    = req_q.region_start;
    wr.length   = req_q.region_length;
    wr.count    = CountW'(1);
    if (state_q == StFinish) begin
      if (req_q.req_type == ReqAdd) begin
        wr.entry_en = found_q || free_q;
      end else if (req_q.req_type == ReqInc || req_q.req_type == ReqDec) begin
        wr.count_en = found_q;
        wr.count    = new_cnt;
      end
    end
  end

  rrs_entry_mem u_entry_mem (
    .clk_i    (clk_i),
    .rd_idx_i (rd_idx_q[IdxW-1:0]),
    .wr_i     (wr),
    .rd_o     (rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      req_q       <= '0;
      thr_q       <= '0;
      defer_en_q  <= 1'b0;
      deferred_q  <= '0;
      used_q      <= '0;
      dead_q      <= '0;
      rd_idx_q    <= '0;
      cmp_idx_q   <= '0;
      cmp_valid_q <= 1'b0;
      found_q     <= 1'b0;
      found_idx_q <= '0;
      found_cnt_q <= '0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_wr) begin
        unique case (paddr[2])
          RegThreshold: thr_q      <= pwdata[ThrW-1:0];
          RegEnable:    defer_en_q <= pwdata[0];
          default:      thr_q      <= thr_q;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            req_q <= req_i;
            if (defer_now) begin
              deferred_q  <= deferred_q + ThrW'(1);
              res_valid_q <= 1'b1;
              res_q       <= {StatDeferred, {AddrW{1'b0}}, {AddrW{1'b0}}, 1'b1};
            end else begin
              state_q <= StScan;
            end
            rd_idx_q    <= '0;
            cmp_valid_q <= 1'b0;
            found_q     <= 1'b0;
            free_q      <= 1'b0;
          end
        end
        StScan: begin
          if (rd_idx_q < IdxCntW'(TableDepth)) begin
            rd_idx_q <= rd_idx_q + IdxCntW'(1);
          end
          cmp_valid_q <= (rd_idx_q < IdxCntW'(TableDepth));
          cmp_idx_q   <= rd_idx_q[IdxW-1:0];
          if (req_q.req_type == ReqSync) begin
            if (freed_ent) begin
              dead_q[cmp_idx_q] <= 1'b1;
              res_valid_q       <= 1'b1;
              res_q             <= {StatFreed, rd.start, rd.length, 1'b0};
            end
          end else begin
            if (hit && !found_q) begin
              found_q     <= 1'b1;
              found_idx_q <= cmp_idx_q;
              found_cnt_q <= rd.count;
            end
            if (cmp_valid_q && !used_q[cmp_idx_q] && !free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= cmp_idx_q;
            end
          end
          if (cmp_valid_q && (cmp_idx_q == IdxW'(TableDepth - 1))) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          res_valid_q <= 1'b1;
          res_q       <= {fin_status, {AddrW{1'b0}}, {AddrW{1'b0}}, 1'b1};
          state_q     <= StIdle;
          if (req_q.req_type == ReqSync) begin
            deferred_q <= '0;
          end
          if (req_q.req_type == ReqAdd && (found_q || free_q)) begin
            used_q[wr_idx] <= 1'b1;
            dead_q[wr_idx] <= 1'b0;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Region reference-count sweeper testbench
// Drives add, inc, dec and sync requests into the region table, mirrors the
// table in a behavioural copy and checks every status report in order. The
// run covers directed corner cases, random traffic under several deferral
// settings with varying sender gaps, and a full table.
// ----------------------------------------------------------------------------
module tb_top;
  import rrs_pkg::*;

  localparam int PoolSize = 40;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  req_t             req       = '0;
  logic             res_valid;
  res_t             res;
  logic             psel      = 1'b0;
  logic             penable   = 1'b0;
  logic             pwrite    = 1'b0;
  logic [2:0]       paddr     = '0;
  logic [31:0]      pwdata    = '0;
  logic [31:0]      prdata;
  logic             pready;

  logic [AddrW-1:0]  mir_start  [TableDepth];
  logic [AddrW-1:0]  mir_length [TableDepth];
  logic [CountW-1:0] mir_count  [TableDepth];
  bit                mir_used   [TableDepth];
  bit                mir_dead   [TableDepth];
  logic [ThrW-1:0]   mir_deferred = '0;
  logic [ThrW-1:0]   cfg_thr      = '0;
  logic              cfg_en       = 1'b0;

  logic [AddrW-1:0]  addr_pool [PoolSize];
  res_t              region_reports_q [$];
  res_t              head_rep;
  int                mismatch_cnt = 0;

  region_refcount_sweeper u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_o       (res),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [AddrW-1:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[AddrW-1:0];
  endfunction

  function automatic req_t mk_req(input logic [1:0] t, input logic [AddrW-1:0] s,
                                  input logic [AddrW-1:0] l);
    req_t r;
    r.req_type      = t;
    r.region_start  = s;
    r.region_length = l;
    return r;
  endfunction

  function automatic void push_report(input logic [2:0] st, input logic [AddrW-1:0] s,
                                      input logic [AddrW-1:0] l, input logic lst);
    res_t rep;
    rep.status       = st;
    rep.freed_start  = s;
    rep.freed_length = l;
    rep.last         = lst;
    region_reports_q.push_back(rep);
  endfunction

  task automatic apply_region_req(input req_t r);
    int slot;
    int i;
    slot = -1;
    case (r.req_type)
      ReqAdd: begin
        for (i = 0; i < TableDepth; i++)
          if (slot < 0 && mir_used[i] && mir_start[i] == r.region_start) slot = i;
        for (i = 0; i < TableDepth; i++)
          if (slot < 0 && !mir_used[i]) slot = i;
        if (slot < 0) begin
          push_report(StatFull, '0, '0, 1'b1);
        end else begin
          mir_used[slot]   = 1'b1;
          mir_dead[slot]   = 1'b0;
          mir_start[slot]  = r.region_start;
          mir_length[slot] = r.region_length;
          mir_count[slot]  = CountW'(1);
          push_report(StatDone, '0, '0, 1'b1);
        end
      end
      ReqInc, ReqDec: begin
        for (i = 0; i < TableDepth; i++)
          if (slot < 0 && mir_used[i] && !mir_dead[i] && mir_start[i] == r.region_start)
            slot = i;
        if (slot < 0) begin
          push_report(StatNoMatch, '0, '0, 1'b1);
        end else begin
          if (mir_count[slot] != 0) begin
            if (r.req_type == ReqInc) begin
              if (mir_count[slot] != CountMax) mir_count[slot] = mir_count[slot] + 1'b1;
            end else begin
              mir_count[slot] = mir_count[slot] - 1'b1;
            end
          end
          push_report(StatDone, '0, '0, 1'b1);
        end
      end
      default: begin
        if (cfg_en && mir_deferred < cfg_thr) begin
          mir_deferred = mir_deferred + 1'b1;
          push_report(StatDeferred, '0, '0, 1'b1);
        end else begin
          for (i = 0; i < TableDepth; i++) begin
            if (mir_used[i] && !mir_dead[i] && mir_count[i] == 0) begin
              mir_dead[i] = 1'b1;
              push_report(StatFreed, mir_start[i], mir_length[i], 1'b0);
            end
          end
          push_report(StatDone, '0, '0, 1'b1);
          mir_deferred = '0;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid) begin
      if (region_reports_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d", $time,
                 res.status);
        mismatch_cnt++;
      end else begin
        head_rep = region_reports_q.pop_front();
        check_field("status", 64'(head_rep.status), 64'(res.status));
        check_field("freed_start", 64'(head_rep.freed_start), 64'(res.freed_start));
        check_field("freed_length", 64'(head_rep.freed_length), 64'(res.freed_length));
        check_field("last", 64'(head_rep.last), 64'(res.last));
      end
    end
  end

  task automatic issue_req(input req_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    apply_region_req(r);
  endtask

  task automatic wait_all_reported();
    start <= 1'b0;
    while (region_reports_q.size() != 0) @(posedge clk_i);
    repeat (TableDepth + 4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic reg_idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == RegThreshold) cfg_thr = val[ThrW-1:0];
    else cfg_en = val[0];
    @(posedge clk_i);
    if (reg_idx == RegThreshold) check_field("prdata", 64'(cfg_thr), 64'(prdata));
    else check_field("prdata", 64'(cfg_en), 64'(prdata));
  endtask

  task automatic set_deferral(input logic [ThrW-1:0] thr, input logic en);
    wait_all_reported();
    cfg_write(RegThreshold, {16'h0, thr});
    cfg_write(RegEnable, {31'h0, en});
  endtask

  task automatic test_directed();
    logic [AddrW-1:0] all_ones;
    all_ones = '1;
    issue_req(mk_req(ReqInc, '0, '0));
    issue_req(mk_req(ReqDec, '0, '0));
    issue_req(mk_req(ReqSync, all_ones, all_ones));
    issue_req(mk_req(ReqAdd, '0, all_ones));
    issue_req(mk_req(ReqAdd, all_ones, '0));
    issue_req(mk_req(ReqAdd, '0, 48'h5));
    issue_req(mk_req(ReqInc, '0, all_ones));
    issue_req(mk_req(ReqDec, all_ones, all_ones));
    issue_req(mk_req(ReqDec, all_ones, '0));
    issue_req(mk_req(ReqInc, 48'h1234_5678_9abc, '0));
    issue_req(mk_req(ReqSync, '0, '0));
    issue_req(mk_req(ReqInc, all_ones, '0));
    issue_req(mk_req(ReqDec, all_ones, '0));
    issue_req(mk_req(ReqAdd, all_ones, 48'ha5a5_5a5a_a5a5));
    issue_req(mk_req(ReqDec, '0, '0));
    issue_req(mk_req(ReqDec, '0, '0));
    issue_req(mk_req(ReqSync, all_ones, '0));
    set_deferral(16'd2, 1'b1);
    issue_req(mk_req(ReqDec, all_ones, '0));
    issue_req(mk_req(ReqSync, '0, '0));
    issue_req(mk_req(ReqSync, '0, '0));
    issue_req(mk_req(ReqSync, '0, '0));
    set_deferral('0, 1'b0);
  endtask

  function automatic req_t random_region_req();
    req_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) r.req_type = ReqAdd;
    else if (pick < 60) r.req_type = ReqInc;
    else if (pick < 85) r.req_type = ReqDec;
    else r.req_type = ReqSync;
    pick = $urandom_range(99);
    if (pick < 85) r.region_start = addr_pool[$urandom_range(PoolSize - 1)];
    else if (pick < 95) r.region_start = rand48();
    else if (pick < 97) r.region_start = '0;
    else r.region_start = '1;
    pick = $urandom_range(99);
    if (pick < 80) r.region_length = rand48();
    else if (pick < 90) r.region_length = '0;
    else r.region_length = '1;
    return r;
  endfunction

  task automatic run_random_phase(input int idle_pct, input int n_items);
    int k;
    for (k = 0; k < n_items; k++) begin
      issue_req(random_region_req());
      if ($urandom_range(99) < 3) begin
        wait_all_reported();
      end else if ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, TableDepth + 8)) @(posedge clk_i);
      end
    end
  endtask

  task automatic test_random_traffic();
    int k;
    for (k = 0; k < PoolSize; k++) addr_pool[k] = rand48();
    set_deferral('0, 1'b1);
    run_random_phase(16, 110);
    set_deferral(16'd2, 1'b1);
    run_random_phase(52, 110);
    set_deferral(16'hffff, 1'b1);
    run_random_phase(0, 80);
    set_deferral(16'hffff, 1'b0);
    run_random_phase(0, 120);
  endtask

  task automatic test_table_full();
    bit has_free;
    int i;
    wait_all_reported();
    do begin
      has_free = 1'b0;
      for (i = 0; i < TableDepth; i++) if (!mir_used[i]) has_free = 1'b1;
      issue_req(mk_req(ReqAdd, rand48(), rand48()));
    end while (has_free);
    issue_req(mk_req(ReqAdd, rand48(), rand48()));
    issue_req(mk_req(ReqDec, mir_start[TableDepth - 1], '0));
    issue_req(mk_req(ReqSync, '0, '0));
    issue_req(mk_req(ReqAdd, rand48(), '0));
    issue_req(mk_req(ReqAdd, mir_start[TableDepth - 1], '1));
    issue_req(mk_req(ReqInc, mir_start[$urandom_range(TableDepth - 1)], '0));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic();
    test_table_full();
    wait_all_reported();
    if (mismatch_cnt == 0 && region_reports_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
